// ===== hdl/lkvc_pkg.sv =====
// shared types and constants for the lru key/value cache
`default_nettype none

package lkvc_pkg;

  localparam int Capacity = 8;
  localparam int KeyBits  = 32;
  localparam int InKeyW   = 32;
  localparam int ValueW   = 64;

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [ValueW-1:0]  value_t;

  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  // per-cell status seen by the control logic
  typedef struct packed {
    logic valid;
    logic match;
  } cell_stat_t;

  typedef enum logic [0:0] {
    OpLookup = 1'b0,
    OpInsert = 1'b1
  } op_e;

endpackage

`default_nettype wire

// ===== hdl/lkvc_cell.sv =====
// one recency position of the cache: entry register, valid bit and key compare
`default_nettype none

module lkvc_cell import lkvc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire entry_t     prev_entry_i,
  input  wire logic       prev_valid_i,
  input  wire key_t       lookup_key_i,
  output entry_t          entry_o,
  output logic            valid_o,
  output cell_stat_t      stat_o
);

  entry_t entry_q;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= prev_entry_i;
    end
  end

  assign entry_o      = entry_q;
  assign valid_o      = valid_q;
  assign stat_o.valid = valid_q;
  assign stat_o.match = valid_q && (entry_q.key == lookup_key_i);

endmodule

`default_nettype wire

// ===== hdl/lru_keyed_value_cache_top.sv =====
// fully associative lru key/value cache built as a chain of recency cells
// the result is registered: it is valid in the cycle after the input transaction is accepted
// throughput: one transaction per cycle while the output is not stalled; the output register is
//   refilled in the cycle it is taken, set by the combinational compare and shift of the cell chain
// reset: all cells invalid (empty cache), output register empty; entry payload
//   is not reset and is never read before it is written
`default_nettype none

module lru_keyed_value_cache_top import lkvc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic [InKeyW-1:0]  key_i,
  input  wire logic [ValueW-1:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic [ValueW-1:0]       result_value_o,
  output logic                    evicted_o,
  output logic [InKeyW-1:0]       evicted_key_o
);

  // cell i holds recency position i, cell 0 is the most recent
  entry_t     cell_entry [Capacity];
  logic       cell_valid [Capacity];
  cell_stat_t cell_stat  [Capacity];
  logic       cell_shift [Capacity];

  key_t   lookup_key;
  logic   accept;
  logic   is_insert;
  logic   hit;
  value_t hit_value;
  logic   full;
  entry_t front_entry;
  logic   prefix_match [Capacity];

  assign lookup_key = KeyBits'(key_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_insert  = (op_e'(operation_i) == OpInsert);
  assign full       = cell_valid[Capacity-1];

  // first match from the front wins; cells up to it slide back one place
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (i == 0) begin
        prefix_match[i] = cell_stat[i].match;
        if (cell_stat[i].match) begin
          hit_value = cell_entry[i].value;
        end
      end else begin
        prefix_match[i] = prefix_match[i-1] || cell_stat[i].match;
        if (cell_stat[i].match && !prefix_match[i-1]) begin
          hit_value = cell_entry[i].value;
        end
      end
    end
    hit = prefix_match[Capacity-1];
  end

  // the front cell takes the new entry on insert or the hit entry on lookup;
  // the hit key equals the lookup key, so only the value needs a select
  assign front_entry.key   = lookup_key;
  assign front_entry.value = is_insert ? value_i : hit_value;

  // insert shifts the whole chain, the last entry falls off when full;
  // a hit shifts only the cells in front of and at the first match
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      if (i == 0) begin
        cell_shift[i] = accept && (is_insert || hit);
      end else begin
        cell_shift[i] = accept && (is_insert || (hit && !prefix_match[i-1]));
      end
    end
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    if (g == 0) begin : g_front
      lkvc_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (cell_shift[g]),
        .prev_entry_i (front_entry),
        .prev_valid_i (1'b1),
        .lookup_key_i (lookup_key),
        .entry_o      (cell_entry[g]),
        .valid_o      (cell_valid[g]),
        .stat_o       (cell_stat[g])
      );
    end else begin : g_rest
      lkvc_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (cell_shift[g]),
        .prev_entry_i (cell_entry[g-1]),
        .prev_valid_i (cell_valid[g-1]),
        .lookup_key_i (lookup_key),
        .entry_o      (cell_entry[g]),
        .valid_o      (cell_valid[g]),
        .stat_o       (cell_stat[g])
      );
    end
  end

  // output register, refilled whenever empty or being drained
  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d;
  logic [ValueW-1:0]   result_value_q, result_value_d;
  logic                evicted_q, evicted_d;
  logic [InKeyW-1:0]   evicted_key_q, evicted_key_d;

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d    = out_valid_q && !out_ready_i;
    found_d        = found_q;
    result_value_d = result_value_q;
    evicted_d      = evicted_q;
    evicted_key_d  = evicted_key_q;
    if (accept) begin
      out_valid_d = 1'b1;
      if (is_insert) begin
        found_d        = 1'b1;
        result_value_d = value_i;
        evicted_d      = full;
        evicted_key_d  = full ? InKeyW'(cell_entry[Capacity-1].key) : '0;
      end else begin
        found_d        = hit;
        result_value_d = hit ? hit_value : '0;
        evicted_d      = 1'b0;
        evicted_key_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q        <= found_d;
    result_value_q <= result_value_d;
    evicted_q      <= evicted_d;
    evicted_key_q  <= evicted_key_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign result_value_o = result_value_q;
  assign evicted_o      = evicted_q;
  assign evicted_key_o  = evicted_key_q;

endmodule

`default_nettype wire

// ===== hdl/lkvc_checker.sv =====
// port-level checks for the lru key/value cache, bound to the top level
`default_nettype none

module lkvc_checker import lkvc_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               operation_i,
  input wire logic [InKeyW-1:0]  key_i,
  input wire logic [ValueW-1:0]  value_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               found_o,
  input wire logic [ValueW-1:0]  result_value_o,
  input wire logic               evicted_o,
  input wire logic [InKeyW-1:0]  evicted_key_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(found_o) && $stable(result_value_o) &&
      $stable(evicted_o) && $stable(evicted_key_o))
    else $error("result changed while stalled");

  // an insert always reports found with the inserted value in the following cycle
  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_e'(operation_i) == OpInsert) |=>
      out_valid_o && found_o && (result_value_o == $past(value_i)))
    else $error("insert result wrong");

  // a lookup never evicts
  a_lookup_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_e'(operation_i) == OpLookup) |=>
      out_valid_o && !evicted_o && (evicted_key_o == '0))
    else $error("lookup reported an eviction");

  // a miss carries a zero value
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (result_value_o == '0) && !evicted_o)
    else $error("miss with nonzero value");

  // evicted key is zero when nothing was evicted
  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> (evicted_key_o == '0))
    else $error("evicted key without eviction");

endmodule

bind lru_keyed_value_cache_top lkvc_checker u_lkvc_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_lru_keyed_value_cache_top.sv =====
// self-checking testbench for the lru key/value cache: recency-order scoreboard and random traffic
`timescale 1ns / 1ps

module tb_lru_keyed_value_cache_top;
  import lkvc_pkg::*;

  localparam int unsigned IdleLimit      = 3000;  // cycles with no transaction before giving up
  localparam int unsigned RandomItems    = 530;
  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned HoldAfterItems = 150;   // input transactions seen before the long hold
  localparam int unsigned DrainAtItem    = 300;   // random item at which the sender waits for empty

  // one result transaction as the block should present it
  typedef struct {
    logic                found;
    value_t              value;
    logic                evicted;
    logic [InKeyW-1:0]   evicted_key;
  } cache_result_t;

  // receiver stall patterns
  typedef enum int unsigned {
    RxAlways,
    RxCoinFlip,
    RxEveryThird
  } rx_mode_e;

  // scoreboard: keeps its own copy of the cache in recency order and a queue of
  // the results still owed by the block
  class lru_scoreboard;
    key_t          slot_key[Capacity];
    value_t        slot_value[Capacity];
    int unsigned   recency[Capacity];  // slot at each position, position 0 most recent
    int unsigned   live_count;
    cache_result_t owed_q[$];
    int unsigned   errors;

    function new();
      int unsigned i;
      for (i = 0; i < Capacity; i++) begin
        recency[i]    = i;
        slot_key[i]   = '0;
        slot_value[i] = '0;
      end
      live_count = 0;
      errors     = 0;
    endfunction

    // move the slot at recency position pos to the front
    function void promote(int unsigned pos);
      int unsigned slot;
      int unsigned i;
      slot = recency[pos];
      for (i = pos; i > 0; i--) recency[i] = recency[i-1];
      recency[0] = slot;
    endfunction

    // work out the result of an accepted request and update the cache copy
    function void note_request(op_e op, logic [InKeyW-1:0] key_in, value_t val);
      cache_result_t r;
      key_t          k;
      int unsigned   pos;
      int unsigned   slot;
      int unsigned   i;
      bit            hit;
      r.found       = 1'b0;
      r.value       = '0;
      r.evicted     = 1'b0;
      r.evicted_key = '0;
      k = key_in[KeyBits-1:0];
      if (op == OpLookup) begin
        // search from most recent, first match wins (duplicates hit the newest copy)
        hit = 1'b0;
        for (i = 0; i < live_count && !hit; i++) begin
          slot = recency[i];
          if (slot_key[slot] == k) begin
            hit     = 1'b1;
            r.found = 1'b1;
            r.value = slot_value[slot];
            promote(i);
          end
        end
      end else begin
        if (live_count == Capacity) begin
          // full: reuse the least recent slot
          pos           = Capacity - 1;
          slot          = recency[pos];
          r.evicted     = 1'b1;
          r.evicted_key = InKeyW'(slot_key[slot]);
        end else begin
          pos  = live_count;
          slot = recency[pos];
          live_count++;
        end
        slot_key[slot]   = k;
        slot_value[slot] = val;
        promote(pos);
        r.found = 1'b1;
        r.value = val;
      end
      owed_q.push_back(r);
    endfunction

    // compare a result transaction with the oldest owed result
    function void check_response(logic found, value_t val, logic evicted,
                                 logic [InKeyW-1:0] ekey);
      cache_result_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: found=%0b value=%h evicted=%0b key=%h",
                 $time, found, val, evicted, ekey);
      end else begin
        e = owed_q.pop_front();
        if (found !== e.found) begin
          errors++;
          $display("%0t: found mismatch, expected %0b actual %0b", $time, e.found, found);
        end
        if (val !== e.value) begin
          errors++;
          $display("%0t: result_value mismatch, expected %h actual %h", $time, e.value, val);
        end
        if (evicted !== e.evicted) begin
          errors++;
          $display("%0t: evicted mismatch, expected %0b actual %0b", $time, e.evicted, evicted);
        end
        if (ekey !== e.evicted_key) begin
          errors++;
          $display("%0t: evicted_key mismatch, expected %h actual %h",
                   $time, e.evicted_key, ekey);
        end
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  op_e               operation = OpLookup;
  logic [InKeyW-1:0] key       = '0;
  value_t            value     = '0;
  logic              out_ready = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic              found;
  value_t            result_value;
  logic              evicted;
  logic [InKeyW-1:0] evicted_key;

  lru_scoreboard     sb;
  int unsigned       requests_taken = 0;

  // key pool so that random lookups hit often
  logic [InKeyW-1:0] key_pool[16];
  int unsigned       pool_span = 15;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_keyed_value_cache_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .key_i          (key),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .found_o        (found),
    .result_value_o (result_value),
    .evicted_o      (evicted),
    .evicted_key_o  (evicted_key)
  );

  // monitor: values read here are the ones before this edge's updates
  always @(posedge clk) begin
    if (rst_n) begin
      // check first so a result can never consume an expectation noted this cycle
      if (out_valid && out_ready) sb.check_response(found, result_value, evicted, evicted_key);
      if (in_valid && in_ready) begin
        sb.note_request(operation, key, value);
        requests_taken++;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_lru_keyed_value_cache_top failed");
    $finish;
  end

  // receiver: segments of different stall patterns, plus one long hold once
  // enough requests went in, so the block fills up and stalls its input
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned span;
    int unsigned phase;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 2));
      span = $urandom_range(10, 60);
      for (phase = 0; phase < span; phase++) begin
        @(posedge clk);
        if (!long_hold_done && requests_taken >= HoldAfterItems) begin
          long_hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (LongHoldCycles) @(posedge clk);
        end
        case (mode)
          RxAlways:   out_ready <= 1'b1;
          RxCoinFlip: out_ready <= ($urandom_range(0, 1) == 1);
          default:    out_ready <= (phase % 3 == 0);
        endcase
      end
    end
  end

  // offer one request and hold it until taken; valid is left high afterwards
  task automatic send_item(op_e op, logic [InKeyW-1:0] k, value_t v);
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    value     <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_input(int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop offering until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic refill_pool();
    int unsigned i;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < 16; i++) key_pool[i] = $urandom;
    pool_span = $urandom_range(3, 15);
  endtask

  initial begin : sender
    int unsigned       n;
    int unsigned       burst_left;
    op_e               op;
    logic [InKeyW-1:0] k;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, key and value extremes, duplicates, fill, eviction
    send_item(OpLookup, '0, '0);                          // miss in empty store
    send_item(OpLookup, '1, '1);                          // miss, value field ignored
    send_item(OpInsert, '0, '0);
    send_item(OpInsert, '1, '1);
    send_item(OpLookup, '0, 64'h0123_4567_89ab_cdef);
    send_item(OpLookup, '1, '0);
    send_item(OpInsert, 32'ha5a5_a5a5, 64'h1);
    send_item(OpInsert, 32'ha5a5_a5a5, 64'h2);            // duplicate key
    send_item(OpLookup, 32'ha5a5_a5a5, '0);               // newest copy must win
    send_item(OpInsert, 32'h0000_0001, {$urandom, $urandom});
    send_item(OpInsert, 32'h0000_0002, {$urandom, $urandom});
    send_item(OpInsert, 32'h0000_0003, {$urandom, $urandom});
    send_item(OpInsert, 32'h0000_0004, {$urandom, $urandom});  // store now full
    send_item(OpInsert, 32'h0000_0005, 64'haaaa_aaaa_aaaa_aaaa); // evicts oldest
    send_item(OpInsert, 32'h0000_0006, 64'h5555_5555_5555_5555);
    send_item(OpLookup, '1, '0);
    send_item(OpLookup, 32'h1234_5678, '0);               // never stored
    send_item(OpLookup, 32'h0000_0004, '0);
    send_item(OpInsert, 32'h5a5a_5a5a, 64'h5555_aaaa_5555_aaaa);
    send_item(OpInsert, 32'h8000_0000, 64'h8000_0000_0000_0000);
    send_item(OpLookup, 32'h0000_0001, '1);
    send_item(OpLookup, 32'ha5a5_a5a5, '0);
    wait_drained();

    // random: mostly keys from a small pool so hits, duplicates and evictions are common
    burst_left = 0;
    for (n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) refill_pool();
      if (n == DrainAtItem) begin
        wait_drained();
      end else if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) pause_input(0);
        else pause_input($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                 : $urandom_range(1, 12);
      end
      op = ($urandom_range(0, 99) < 45) ? OpInsert : OpLookup;
      if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, pool_span)];
      else k = $urandom;
      send_item(op, k, {$urandom, $urandom});
      if (burst_left > 0) burst_left--;
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_lru_keyed_value_cache_top passed");
    end else begin
      $display("tb_lru_keyed_value_cache_top failed");
    end
    $finish;
  end

endmodule
